// File: src/imuoc_pkg.sv
// ----------------------------------------------------------------------------
// IMU offset auto-calibrator package
// Shared payload types, controller/datapath interface and constants.
// ----------------------------------------------------------------------------
package imuoc_pkg;

  // Axis layout: accelerometer x, y, z then gyro x, y, z.
  localparam int NUM_AXES   = 6;
  localparam int ACCEL_AXES = 3;
  localparam int AXIS_W     = 3;

  // Configuration register defaults.
  localparam logic [15:0] SAMPLE_COUNT_RST   = 16'd1000;
  localparam logic [14:0] ACCEL_DEADZONE_RST = 15'd1;
  localparam logic [14:0] GYRO_DEADZONE_RST  = 15'd1;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_SAMPLE_COUNT   = 2'd0,
    CFG_ACCEL_DEADZONE = 2'd1,
    CFG_GYRO_DEADZONE  = 2'd2
  } cfg_index_t;

  // Operand selection for the shared divider.
  typedef enum logic {
    DIV_MEAN = 1'b0,
    DIV_STEP = 1'b1
  } div_sel_t;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
  } imu_sample_t;

  typedef struct packed {
    logic signed [15:0] cor_accel_x;
    logic signed [15:0] cor_accel_y;
    logic signed [15:0] cor_accel_z;
    logic signed [15:0] cor_gyro_x;
    logic signed [15:0] cor_gyro_y;
    logic signed [15:0] cor_gyro_z;
    logic               calib_done;
  } imu_result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              accept;
    logic              div_start;
    div_sel_t          div_sel;
    logic [AXIS_W-1:0] axis;
    logic              finish;
    logic              all_settled;
  } imuoc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic round_end;
    logic div_done;
    logic settled;
  } imuoc_stat_t;

endpackage

// File: src/imuoc_dp.sv
// ----------------------------------------------------------------------------
// IMU offset auto-calibrator datapath
// Configuration registers, offsets, round sums, output register and the
// shared restoring divider used for the means and the offset steps.
// ----------------------------------------------------------------------------
module imuoc_dp import imuoc_pkg::*; #(
  parameter int SUM_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [15:0] wr_data,
  input  imu_sample_t in_data,
  output imu_result_t out_data,
  input  imuoc_cmd_t  cmd,
  output imuoc_stat_t stat
);

  localparam int CNT_W = $clog2(SUM_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SUM_BITS - 1);

  // Configuration registers.
  logic [15:0] sample_count;
  logic [14:0] accel_deadzone;
  logic [14:0] gyro_deadzone;

  // Calibration state.
  logic [15:0]         offset [NUM_AXES];
  logic [SUM_BITS-1:0] axis_sum [NUM_AXES];
  logic [15:0]         round_samples;
  logic                done_flag;
  logic [15:0]         mean;

  // Divider registers.
  logic                div_busy;
  logic                div_done;
  logic [CNT_W-1:0]    div_cnt;
  logic [15:0]         div_rem;
  logic [15:0]         div_den;
  logic [SUM_BITS-1:0] div_quo;
  logic                div_neg;

  // Accept-side signals.
  logic [15:0]         raw [NUM_AXES];
  logic [15:0]         cor [NUM_AXES];
  logic [SUM_BITS-1:0] sum_add [NUM_AXES];
  logic [15:0]         round_inc;
  logic [15:0]         count_eff;

  // Operand selection signals.
  logic [SUM_BITS-1:0] sum_sel;
  logic [SUM_BITS-1:0] sum_mag;
  logic [16:0]         mean_ext;
  logic [16:0]         mean_mag;
  logic                is_accel;
  logic [14:0]         tol;
  logic [15:0]         step_den;
  logic [16:0]         trial;
  logic                trial_ge;
  logic [15:0]         quo16;

  assign raw[0] = in_data.accel_x;
  assign raw[1] = in_data.accel_y;
  assign raw[2] = in_data.accel_z;
  assign raw[3] = in_data.gyro_x;
  assign raw[4] = in_data.gyro_y;
  assign raw[5] = in_data.gyro_z;

  // Corrected sample and running sums for the incoming transaction.
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      cor[i]     = raw[i] + offset[i];
      sum_add[i] = axis_sum[i] + {{(SUM_BITS-16){cor[i][15]}}, cor[i]};
    end
  end

  // A zero sample count behaves as a count of one.
  assign count_eff = (sample_count == 16'd0) ? 16'd1 : sample_count;
  assign round_inc = round_samples + 16'd1;
  assign stat.round_end = !done_flag && ((round_inc >= count_eff) || (round_inc == 16'd0));

  // Operands for the axis under evaluation.
  always_comb begin
    sum_sel  = axis_sum[cmd.axis];
    sum_mag  = sum_sel[SUM_BITS-1] ? (SUM_BITS'(0) - sum_sel) : sum_sel;
    mean_ext = {mean[15], mean};
    mean_mag = mean[15] ? (17'd0 - mean_ext) : mean_ext;
    is_accel = (cmd.axis < AXIS_W'(ACCEL_AXES));
    tol      = is_accel ? accel_deadzone : gyro_deadzone;
    if (is_accel) begin
      step_den = (accel_deadzone == 15'd0) ? 16'd1 : {1'b0, accel_deadzone};
    end else begin
      step_den = {1'b0, gyro_deadzone} + 16'd1;
    end
  end

  assign stat.settled  = (mean_mag <= {2'b00, tol});
  assign stat.div_done = div_done;

  // One restoring division step per cycle, and the signed low half of the quotient.
  assign trial    = {div_rem, div_quo[SUM_BITS-1]};
  assign trial_ge = (trial >= {1'b0, div_den});
  assign quo16    = div_neg ? (16'd0 - div_quo[15:0]) : div_quo[15:0];

  // Configuration writes; an index beyond the register list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count   <= SAMPLE_COUNT_RST;
      accel_deadzone <= ACCEL_DEADZONE_RST;
      gyro_deadzone  <= GYRO_DEADZONE_RST;
    end else if (wr_en) begin
      unique case (cfg_index_t'(wr_index))
        CFG_SAMPLE_COUNT:   sample_count   <= wr_data;
        CFG_ACCEL_DEADZONE: accel_deadzone <= wr_data[14:0];
        CFG_GYRO_DEADZONE:  gyro_deadzone  <= wr_data[14:0];
        default: ;
      endcase
    end
  end

  // Shared divider: load, iterate through SUM_BITS quotient bits, then flag completion.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_done <= 1'b0;
      div_cnt  <= '0;
    end else begin
      div_done <= div_busy && (div_cnt == CNT_LAST);
      if (cmd.div_start) begin
        div_busy <= 1'b1;
        div_cnt  <= '0;
      end else if (div_busy) begin
        div_cnt <= div_cnt + CNT_W'(1);
        if (div_cnt == CNT_LAST) begin
          div_busy <= 1'b0;
        end
      end
    end
  end

  // Divider payload registers.
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_rem <= '0;
      if (cmd.div_sel == DIV_MEAN) begin
        div_quo <= sum_mag;
        div_den <= count_eff;
        div_neg <= sum_sel[SUM_BITS-1];
      end else begin
        div_quo <= {{(SUM_BITS-17){1'b0}}, mean_mag};
        div_den <= step_den;
        div_neg <= mean[15];
      end
    end else if (div_busy) begin
      div_rem <= trial_ge ? 16'(trial - {1'b0, div_den}) : trial[15:0];
      div_quo <= {div_quo[SUM_BITS-2:0], trial_ge};
    end
  end

  // Calibration state: sums, round count, offsets and the done flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        offset[i]   <= '0;
        axis_sum[i] <= '0;
      end
      round_samples <= '0;
      done_flag     <= 1'b0;
    end else begin
      if (cmd.accept && !done_flag) begin
        for (int i = 0; i < NUM_AXES; i++) begin
          axis_sum[i] <= sum_add[i];
        end
        round_samples <= round_inc;
      end
      if (div_done && (cmd.div_sel == DIV_STEP)) begin
        offset[cmd.axis] <= offset[cmd.axis] - quo16;
      end
      if (cmd.finish) begin
        if (cmd.all_settled) begin
          done_flag <= 1'b1;
        end else begin
          for (int i = 0; i < NUM_AXES; i++) begin
            axis_sum[i] <= '0;
          end
          round_samples <= '0;
        end
      end
    end
  end

  // Capture the mean once its division completes.
  always_ff @(posedge clk) begin
    if (div_done && (cmd.div_sel == DIV_MEAN)) begin
      mean <= quo16;
    end
  end

  // Output register: corrected sample on acceptance, done flag at round end.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      out_data.cor_accel_x <= cor[0];
      out_data.cor_accel_y <= cor[1];
      out_data.cor_accel_z <= cor[2];
      out_data.cor_gyro_x  <= cor[3];
      out_data.cor_gyro_y  <= cor[4];
      out_data.cor_gyro_z  <= cor[5];
      out_data.calib_done  <= done_flag;
    end else if (cmd.finish) begin
      out_data.calib_done <= cmd.all_settled;
    end
  end

endmodule

// File: src/imuoc_ctrl.sv
// ----------------------------------------------------------------------------
// IMU offset auto-calibrator controller
// Handshake control and the end-of-round sequence over the six axes.
// ----------------------------------------------------------------------------
module imuoc_ctrl import imuoc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output imuoc_cmd_t  cmd,
  input  imuoc_stat_t stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MEAN_WAIT,
    S_CHECK,
    S_STEP_WAIT,
    S_FINISH
  } state_t;

  state_t            state;
  logic              accept;
  logic              div_start;
  div_sel_t          div_sel;
  logic [AXIS_W-1:0] axis;
  logic              finish;
  logic              all_settled;
  logic              last_axis;

  // A new sample is taken when idle and the output register is free or draining.
  assign in_ready  = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept    = in_valid && in_ready;
  assign last_axis = (axis == AXIS_W'(NUM_AXES - 1));

  assign cmd.accept      = accept;
  assign cmd.div_start   = div_start;
  assign cmd.div_sel     = div_sel;
  assign cmd.axis        = axis;
  assign cmd.finish      = finish;
  assign cmd.all_settled = all_settled;

  // State register and registered commands.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      div_start   <= 1'b0;
      div_sel     <= DIV_MEAN;
      axis        <= '0;
      finish      <= 1'b0;
      all_settled <= 1'b1;
    end else begin
      div_start <= 1'b0;
      finish    <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (stat.round_end) begin
              axis        <= '0;
              all_settled <= 1'b1;
              div_sel     <= DIV_MEAN;
              div_start   <= 1'b1;
              state       <= S_MEAN_WAIT;
            end else begin
              out_valid <= 1'b1;
            end
          end
        end
        S_MEAN_WAIT: begin
          if (stat.div_done) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (!stat.settled) begin
            all_settled <= 1'b0;
            div_sel     <= DIV_STEP;
            div_start   <= 1'b1;
            state       <= S_STEP_WAIT;
          end else if (last_axis) begin
            finish <= 1'b1;
            state  <= S_FINISH;
          end else begin
            axis      <= axis + AXIS_W'(1);
            div_sel   <= DIV_MEAN;
            div_start <= 1'b1;
            state     <= S_MEAN_WAIT;
          end
        end
        S_STEP_WAIT: begin
          if (stat.div_done) begin
            if (last_axis) begin
              finish <= 1'b1;
              state  <= S_FINISH;
            end else begin
              axis      <= axis + AXIS_W'(1);
              div_sel   <= DIV_MEAN;
              div_start <= 1'b1;
              state     <= S_MEAN_WAIT;
            end
          end
        end
        S_FINISH: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: src/imu_offset_autocalibrator.sv
// An accepted sample's result is registered and valid in the next cycle, except at the
// end of a round, where one shared bit-serial divider works through the six axes,
// computing the mean and, if the axis is unsettled, an offset step for each axis.
// Throughput: one sample per cycle while results are taken, outside a round end.
// Reset: synchronous, active high; offsets, sums, round count and done flag clear,
// and the configuration registers return to sample_count 1000, deadzones 1.
// ----------------------------------------------------------------------------
// IMU offset auto-calibrator
// Applies per-axis offsets to six-axis samples and tunes the offsets from
// averaged rounds until every axis lies within its deadzone.
// ----------------------------------------------------------------------------
module imu_offset_autocalibrator import imuoc_pkg::*; #(
  parameter int SUM_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [15:0] wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  imu_sample_t in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output imu_result_t out_data
);

  imuoc_cmd_t  cmd;
  imuoc_stat_t stat;

  // Controller: handshakes and the end-of-round sequence.
  imuoc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Datapath: offsets, sums, divider and output register.
  imuoc_dp #(
    .SUM_BITS (SUM_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .in_data  (in_data),
    .out_data (out_data),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule
